@@ sv/ple_pkg.sv @@
// shared types and constants for the positional list engine
// used by ple_ctrl, ple_datapath and positional_list_engine; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   localparam int CAPACITY = 1024;
   localparam int DATA_W   = 16;
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 11;
   localparam int LEN_W    = 11;
   localparam int ADDR_W   = $clog2(CAPACITY);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ     = 3'd0,
      FUNC_INS_HEAD = 3'd1,
      FUNC_INS_TAIL = 3'd2,
      FUNC_INS_AT   = 3'd3,
      FUNC_DELETE   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_INVALID = 2'd1,
      STAT_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_READ,
      OP_INSERT,
      OP_DELETE,
      OP_BAD
   } op_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_LOAD_LEN,
      PTR_LOAD_POS,
      PTR_DEC,
      PTR_INC
   } ptr_op_type;

   typedef struct packed {
      logic       capture;
      ptr_op_type ptr_op;
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mem_wr;
      logic       wr_new;
      logic       len_inc;
      logic       len_dec;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_with_data;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   idx_bad;
      logic   full;
      logic   more;
      logic   rsp_free;
   } stat_type;

endpackage

`default_nettype wire

@@ sv/positional_list_engine.sv @@
// top level of the positional list engine
// depends on ple_pkg, ple_ctrl and ple_datapath
//
//   channel   ports                                      direction
//   request   req_valid req_func req_position req_data_in in
//             req_stall                                  out
//   response  rsp_valid rsp_read_data rsp_status rsp_length out
//             rsp_stall                                  in
//
// a read or a rejected request passes through the check and done states
// an insert or delete also passes through a move read and a move write per element moved
// each moved element costs a read and a write of the element memory
// reset is synchronous; it clears the length and the response valid, not the cells
// a new request is taken while a finished response waits under rsp_stall
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine
   import ple_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic [DATA_W-1:0] req_data_in,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [DATA_W-1:0]      rsp_read_data,
   output logic [1:0]             rsp_status,
   output logic [LEN_W-1:0]       rsp_length
);

   cmd_type  cmd;
   stat_type stat;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ple_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_func),
      .req_position  (req_position),
      .req_data_in   (req_data_in),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status),
      .rsp_length    (rsp_length),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

`default_nettype wire

@@ sv/ple_ctrl.sv @@
// controller state machine for the positional list engine
// depends on ple_pkg; drives ple_datapath through cmd_type, watches stat_type
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl
   import ple_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MOVE_RD,
      S_MOVE_WR,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       with_data_ff, with_data_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.ptr_op    = PTR_HOLD;
      cmd.rd_sel    = RD_POS;
      cmd.rsp_status = status_ff;
      cmd.rsp_with_data = with_data_ff;
      state_in      = state_ff;
      status_in     = status_ff;
      with_data_in  = with_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in    = STAT_DONE;
            with_data_in = 1'b0;
            priority if (stat.op == OP_BAD || stat.idx_bad) begin
               status_in = STAT_INVALID;
               state_in  = S_DONE;
            end else if (stat.op == OP_INSERT && stat.full) begin
               status_in = STAT_FULL;
               state_in  = S_DONE;
            end else if (stat.op == OP_READ) begin
               cmd.mem_rd   = 1'b1;
               cmd.rd_sel   = RD_POS;
               with_data_in = 1'b1;
               state_in     = S_DONE;
            end else if (stat.op == OP_INSERT) begin
               cmd.ptr_op = PTR_LOAD_LEN;
               state_in   = S_MOVE_RD;
            end else begin
               cmd.ptr_op = PTR_LOAD_POS;
               state_in   = S_MOVE_RD;
            end
         end
         S_MOVE_RD: begin
            if (stat.more) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = (stat.op == OP_INSERT) ? RD_PREV : RD_NEXT;
               state_in   = S_MOVE_WR;
            end else begin
               if (stat.op == OP_INSERT) begin
                  cmd.mem_wr  = 1'b1;
                  cmd.wr_new  = 1'b1;
                  cmd.len_inc = 1'b1;
               end else begin
                  cmd.len_dec = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_MOVE_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.ptr_op = (stat.op == OP_INSERT) ? PTR_DEC : PTR_INC;
            state_in   = S_MOVE_RD;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STAT_DONE;
         with_data_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         with_data_ff <= with_data_in;
      end
   end

   a_accept_to_check : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_CHECK)
      else $error("accepted request did not move to check");

   a_rsp_load_free : assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free)
      else $error("response loaded over an unread response");

   a_len_one_way : assert property (@(posedge clock) disable iff (reset)
      !(cmd.len_inc && cmd.len_dec))
      else $error("length incremented and decremented together");

endmodule

`default_nettype wire

@@ sv/ple_datapath.sv @@
// datapath: request capture, element memory, length and move pointer, response register
// depends on ple_pkg; controlled by ple_ctrl through cmd_type
`timescale 1ns / 1ps
`default_nettype none

module ple_datapath
   import ple_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic [DATA_W-1:0] req_data_in,
   output logic [DATA_W-1:0]      rsp_read_data,
   output logic [1:0]             rsp_status,
   output logic [LEN_W-1:0]       rsp_length,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire cmd_type           cmd,
   output stat_type               stat
);

   logic [DATA_W-1:0] mem [CAPACITY];

   logic [FUNC_W-1:0] func_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] data_ff;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  ptr_ff, ptr_in;
   logic [DATA_W-1:0] rd_q_ff;
   logic [DATA_W-1:0] rsp_read_data_ff;
   logic [1:0]        rsp_status_ff;
   logic [LEN_W-1:0]  rsp_length_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [LEN_W-1:0]  tgt;
   logic [LEN_W-1:0]  rd_addr_full;
   logic [LEN_W-1:0]  ptr_next;

   assign ptr_next = ptr_ff + LEN_W'(1);

   always_comb begin
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
      stat.full     = (len_ff == LEN_W'(CAPACITY));
      tgt           = '0;
      unique case (func_ff)
         FUNC_READ: begin
            stat.op      = OP_READ;
            stat.idx_bad = (pos_ff >= len_ff);
         end
         FUNC_INS_HEAD: begin
            stat.op      = OP_INSERT;
            stat.idx_bad = 1'b0;
            tgt          = '0;
         end
         FUNC_INS_TAIL: begin
            stat.op      = OP_INSERT;
            stat.idx_bad = 1'b0;
            tgt          = len_ff;
         end
         FUNC_INS_AT: begin
            stat.op      = OP_INSERT;
            stat.idx_bad = (pos_ff > len_ff);
            tgt          = pos_ff;
         end
         FUNC_DELETE: begin
            stat.op      = OP_DELETE;
            stat.idx_bad = (pos_ff >= len_ff);
         end
         default: begin
            stat.op      = OP_BAD;
            stat.idx_bad = 1'b1;
         end
      endcase
      stat.more = (stat.op == OP_INSERT) ? (ptr_ff > tgt) : (ptr_next < len_ff);
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PREV: rd_addr_full = ptr_ff - LEN_W'(1);
         RD_NEXT: rd_addr_full = ptr_next;
         default: rd_addr_full = pos_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.ptr_op)
         PTR_LOAD_LEN: ptr_in = len_ff;
         PTR_LOAD_POS: ptr_in = pos_ff;
         PTR_DEC:      ptr_in = ptr_ff - LEN_W'(1);
         PTR_INC:      ptr_in = ptr_next;
         default:      ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      priority if (cmd.len_inc) begin
         len_in = len_ff + LEN_W'(1);
      end else if (cmd.len_dec) begin
         len_in = len_ff - LEN_W'(1);
      end else begin
         len_in = len_ff;
      end
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // element memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[ptr_ff[ADDR_W-1:0]] <= cmd.wr_new ? data_ff : rd_q_ff;
      end
      if (cmd.mem_rd) begin
         rd_q_ff <= mem[rd_addr_full[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         pos_ff  <= req_position;
         data_ff <= req_data_in;
      end
      ptr_ff <= ptr_in;
      if (cmd.rsp_load) begin
         rsp_read_data_ff <= cmd.rsp_with_data ? rd_q_ff : '0;
         rsp_status_ff    <= cmd.rsp_status;
         rsp_length_ff    <= len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_length    = rsp_length_ff;
   assign rsp_valid     = rsp_valid_ff;

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(CAPACITY))
      else $error("length beyond capacity");

   a_wr_in_range : assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr |-> ptr_ff < LEN_W'(CAPACITY))
      else $error("memory write outside the cells");

   a_len_step : assert property (@(posedge clock) disable iff (reset)
      (len_ff != $past(len_ff)) |->
         (len_ff == $past(len_ff) + LEN_W'(1) || len_ff == $past(len_ff) - LEN_W'(1)))
      else $error("length moved by more than one");

endmodule

`default_nettype wire
